// ===== design/mcs_pkg.sv =====
// Shared types and constants for the multichannel curve smoother.
// Used by mcs_front, mcs_back and the top module; depends on nothing.
package mcs_pkg;

  localparam int CH_W    = 4;
  localparam int VAL_W   = 24;
  localparam int DT_W    = 16;
  localparam int ALPHA_W = 17;

  // Alpha of one in Q1.16.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // Configuration register indexes (word address bits).
  localparam logic [2:0] REG_PEAK_EN   = 3'd0;
  localparam logic [2:0] REG_PEAK_THR  = 3'd1;
  localparam logic [2:0] REG_PEAK_HOLD = 3'd2;
  localparam logic [2:0] REG_PEAK_RATE = 3'd3;
  localparam logic [2:0] REG_SMOOTH    = 3'd4;
  localparam logic [2:0] REG_CONST     = 3'd5;

  typedef struct packed {
    logic             peak_en;
    logic [VAL_W-1:0] peak_thr;
    logic [VAL_W-1:0] peak_hold;
    logic [VAL_W-1:0] peak_rate;
    logic [VAL_W-1:0] smooth_rate;
    logic             const_mode;
  } cfg_t;

  // Classified input beat as it waits between front and back.
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic               in_range;
    logic [VAL_W-1:0]   value;
    logic [DT_W-1:0]    dt;
    logic [ALPHA_W-1:0] alpha;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
    logic             active;
  } res_t;

endpackage

// ===== design/mcs_fifo.sv =====
// Small synchronous queue with full and empty flags.
// Generic storage; no package dependency.
module mcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/mcs_front.sv =====
// Input side: clamps alpha, checks the channel range and queues the beat.
// Depends on mcs_pkg and mcs_fifo.
module mcs_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [mcs_pkg::CH_W-1:0]     in_channel,
  input  logic [mcs_pkg::VAL_W-1:0]    in_new_value,
  input  logic [mcs_pkg::DT_W-1:0]     in_frame_time,
  input  logic [mcs_pkg::ALPHA_W-1:0]  in_blend_alpha,
  input  logic                         q_pop,
  output logic                         q_empty,
  output mcs_pkg::cmd_t                q_data
);

  mcs_pkg::cmd_t                  cmd;
  logic [$bits(mcs_pkg::cmd_t)-1:0] q_raw;

  always_comb begin
    cmd.channel  = in_channel;
    cmd.in_range = (32'(in_channel) < NUM_CHANNELS);
    cmd.value    = in_new_value;
    cmd.dt       = in_frame_time;
    cmd.alpha    = (in_blend_alpha > mcs_pkg::ALPHA_ONE) ? mcs_pkg::ALPHA_ONE
                                                         : in_blend_alpha;
  end

  mcs_fifo #(
    .WIDTH($bits(mcs_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .pop   (q_pop),
    .wdata (cmd),
    .rdata (q_raw),
    .full  (in_full),
    .empty (q_empty)
  );

  assign q_data = mcs_pkg::cmd_t'(q_raw);

endmodule

// ===== design/mcs_back.sv =====
// Execution side: per-channel state store and a sequencer around one
// shared 24x24 multiplier. Depends on mcs_pkg.
module mcs_back #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mcs_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  mcs_pkg::cmd_t q_data,
  output logic          q_pop,
  input  logic          res_full,
  output logic          res_push,
  output mcs_pkg::res_t res_data
);

  localparam int MAX_CH = 1 << mcs_pkg::CH_W;
  localparam int DEPTH  = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW     = mcs_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_THR, S_WIN, S_PMUL, S_PAPPLY,
    S_SRATE, S_SAPPLY, S_BMUL, S_BAPPLY, S_DONE
  } state_t;

  state_t state_r;

  // Per-channel state.
  logic [VW-1:0] sv_mem [DEPTH];
  logic [VW-1:0] ps_mem [DEPTH];
  logic [VW-1:0] pk_mem [DEPTH];
  logic [VW-1:0] tm_mem [DEPTH];
  logic          on_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  mcs_pkg::cmd_t item_r;
  logic [VW-1:0] cur_r, prev_r, pk_r, tmr_r, sm_r, outv_r, jmag_r;
  logic          on_r, run_r, active_r, neg_r;
  logic [47:0]   prod_r;

  logic [AW-1:0] rd_idx, wr_idx;
  logic          rd_vld, wr_en;

  // Shared multiplier and difference unit.
  logic [VW-1:0] mul_a, mul_b;
  logic [47:0]   mul_p;
  logic [VW-1:0] dx, dy;
  logic [VW:0]   diff;
  logic          dneg;
  logic [VW-1:0] dmag;

  // Rounded apply: base +/- round(prod_r / 2^16).
  logic [VW-1:0] base;
  logic [48:0]   rnd;
  logic [35:0]   adj;
  logic [VW-1:0] applied;

  // Peak window decision.
  logic          jump, on_eff, win_run;
  logic [VW-1:0] tmr_eff;
  logic [VW:0]   tmr_sum;
  logic [VW-1:0] cstep;
  logic [35:0]   cstep_sum;

  function automatic logic [VW-1:0] sat24(input logic [35:0] x);
    logic signed [35:0] sx;
    sx = $signed(x);
    if (sx > 36'sd8388607) begin
      sat24 = 24'h7FFFFF;
    end else if (sx < -36'sd8388608) begin
      sat24 = 24'h800000;
    end else begin
      sat24 = x[VW-1:0];
    end
  endfunction

  assign rd_idx = q_data.channel[AW-1:0];
  assign rd_vld = vld_r[rd_idx];
  assign wr_idx = item_r.channel[AW-1:0];
  assign wr_en  = (state_r == S_DONE) && item_r.in_range;

  assign q_pop    = (state_r == S_IDLE) && !q_empty && !res_full;
  assign res_push = (state_r == S_DONE);
  always_comb begin
    res_data.channel = item_r.channel;
    res_data.value   = outv_r;
    res_data.active  = active_r;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dx    = '0;
    dy    = '0;
    base  = item_r.value;
    case (state_r)
      S_THR: begin
        mul_a = cfg.peak_thr;
        mul_b = VW'(item_r.dt);
        dx    = prev_r;
        dy    = item_r.value;
      end
      S_WIN: begin
        mul_a = cfg.peak_rate;
        mul_b = VW'(item_r.dt);
      end
      S_PMUL: begin
        dx    = pk_r;
        dy    = item_r.value;
        mul_a = dmag;
        mul_b = prod_r[39:16];
      end
      S_PAPPLY: begin
        mul_a = cfg.smooth_rate;
        mul_b = VW'(item_r.dt);
        base  = pk_r;
      end
      S_SRATE: begin
        dx    = cur_r;
        dy    = item_r.value;
        mul_a = dmag;
        mul_b = prod_r[39:16];
      end
      S_SAPPLY: begin
        base = cur_r;
      end
      S_BMUL: begin
        dx    = item_r.value;
        dy    = sm_r;
        mul_a = dmag;
        mul_b = VW'(item_r.alpha);
      end
      default: begin
        base = item_r.value;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign diff  = {dy[VW-1], dy} - {dx[VW-1], dx};
  assign dneg  = diff[VW];
  assign dmag  = dneg ? VW'(-diff) : diff[VW-1:0];

  assign rnd     = {1'b0, prod_r} + 49'd32768;
  assign adj     = neg_r ? (36'd0 - {3'b0, rnd[48:16]}) : {3'b0, rnd[48:16]};
  assign applied = sat24({{12{base[VW-1]}}, base} + adj);

  // A jump restarts the window; the window runs only below the hold time.
  assign jump    = {jmag_r, 16'b0} > prod_r[39:0];
  assign on_eff  = on_r || jump;
  assign tmr_eff = jump ? '0 : tmr_r;
  assign win_run = on_eff && (tmr_eff < cfg.peak_hold);
  assign tmr_sum = {1'b0, tmr_eff} + (VW+1)'(item_r.dt);

  assign cstep     = prod_r[39:16];
  assign cstep_sum = dneg ? ({{12{cur_r[VW-1]}}, cur_r} - {12'b0, cstep})
                          : ({{12{cur_r[VW-1]}}, cur_r} + {12'b0, cstep});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sv_mem[wr_idx] <= cur_r;
      ps_mem[wr_idx] <= prev_r;
      pk_mem[wr_idx] <= pk_r;
      tm_mem[wr_idx] <= tmr_r;
      on_mem[wr_idx] <= on_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            item_r   <= q_data;
            cur_r    <= rd_vld ? sv_mem[rd_idx] : '0;
            prev_r   <= rd_vld ? ps_mem[rd_idx] : '0;
            pk_r     <= rd_vld ? pk_mem[rd_idx] : '0;
            tmr_r    <= rd_vld ? tm_mem[rd_idx] : '0;
            on_r     <= rd_vld ? on_mem[rd_idx] : 1'b0;
            outv_r   <= q_data.value;
            active_r <= 1'b0;
            run_r    <= 1'b0;
            state_r  <= q_data.in_range ? S_THR : S_DONE;
          end
        end
        S_THR: begin
          prod_r  <= mul_p;
          jmag_r  <= dmag;
          state_r <= S_WIN;
        end
        S_WIN: begin
          prod_r <= mul_p;
          if (cfg.peak_en) begin
            prev_r <= item_r.value;
            if (on_eff) begin
              run_r <= win_run;
              on_r  <= win_run;
              tmr_r <= win_run ? (tmr_sum[VW] ? '1 : tmr_sum[VW-1:0]) : tmr_eff;
            end else begin
              pk_r <= item_r.value;
            end
          end
          state_r <= S_PMUL;
        end
        S_PMUL: begin
          prod_r  <= mul_p;
          neg_r   <= dneg;
          state_r <= S_PAPPLY;
        end
        S_PAPPLY: begin
          prod_r <= mul_p;
          if (run_r) begin
            pk_r     <= applied;
            outv_r   <= applied;
            active_r <= 1'b1;
          end
          state_r <= S_SRATE;
        end
        S_SRATE: begin
          prod_r <= mul_p;
          neg_r  <= dneg;
          if (cfg.smooth_rate == '0) begin
            state_r <= S_DONE;
          end else if (cfg.const_mode) begin
            // Constant step lands on the sample once within one step of it.
            sm_r    <= ({dmag, 16'b0} <= prod_r[39:0]) ? item_r.value
                                                       : sat24(cstep_sum);
            state_r <= S_BMUL;
          end else begin
            state_r <= S_SAPPLY;
          end
        end
        S_SAPPLY: begin
          sm_r    <= applied;
          state_r <= S_BMUL;
        end
        S_BMUL: begin
          prod_r  <= mul_p;
          neg_r   <= dneg;
          state_r <= S_BAPPLY;
        end
        S_BAPPLY: begin
          cur_r   <= applied;
          outv_r  <= applied;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (item_r.in_range) begin
            vld_r[wr_idx] <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/multichannel_curve_smoother_unit.sv =====
// An accepted input beat passes the input queue, then the sequencer, before
// its result reaches the out side; constant-step mode skips the sequencer's
// smoothing apply step, and a smooth_rate of zero skips from the smoothing
// rate step to done. The sequencer takes one item at a time, around the
// single shared 24x24 multiplier, and only while the result queue has room.
// Reset (rst_n low, synchronous) clears the settings, the sequencer state,
// both queues and the per-channel valid bits, so each channel reads zero state.
module multichannel_curve_smoother_unit #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [mcs_pkg::CH_W-1:0]    in_channel,
  input  logic [mcs_pkg::VAL_W-1:0]   in_new_value,
  input  logic [mcs_pkg::DT_W-1:0]    in_frame_time,
  input  logic [mcs_pkg::ALPHA_W-1:0] in_blend_alpha,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [mcs_pkg::CH_W-1:0]    out_channel,
  output logic [mcs_pkg::VAL_W-1:0]   out_value,
  output logic                        out_peak_window_active,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [4:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  mcs_pkg::cfg_t cfg_r;
  logic          cfg_we;
  logic [2:0]    cfg_idx;

  logic          q_empty, q_pop;
  mcs_pkg::cmd_t q_data;
  logic          res_full, res_push;
  mcs_pkg::res_t res_data, res_head;
  logic [$bits(mcs_pkg::res_t)-1:0] res_raw;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mcs_pkg::REG_PEAK_EN:   cfg_r.peak_en     <= cfg_pwdata[0];
        mcs_pkg::REG_PEAK_THR:  cfg_r.peak_thr    <= cfg_pwdata[23:0];
        mcs_pkg::REG_PEAK_HOLD: cfg_r.peak_hold   <= cfg_pwdata[23:0];
        mcs_pkg::REG_PEAK_RATE: cfg_r.peak_rate   <= cfg_pwdata[23:0];
        mcs_pkg::REG_SMOOTH:    cfg_r.smooth_rate <= cfg_pwdata[23:0];
        mcs_pkg::REG_CONST:     cfg_r.const_mode  <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mcs_pkg::REG_PEAK_EN:   cfg_prdata = {31'b0, cfg_r.peak_en};
      mcs_pkg::REG_PEAK_THR:  cfg_prdata = {8'b0, cfg_r.peak_thr};
      mcs_pkg::REG_PEAK_HOLD: cfg_prdata = {8'b0, cfg_r.peak_hold};
      mcs_pkg::REG_PEAK_RATE: cfg_prdata = {8'b0, cfg_r.peak_rate};
      mcs_pkg::REG_SMOOTH:    cfg_prdata = {8'b0, cfg_r.smooth_rate};
      mcs_pkg::REG_CONST:     cfg_prdata = {31'b0, cfg_r.const_mode};
      default:                cfg_prdata = '0;
    endcase
  end

  mcs_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_channel     (in_channel),
    .in_new_value   (in_new_value),
    .in_frame_time  (in_frame_time),
    .in_blend_alpha (in_blend_alpha),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_data         (q_data)
  );

  mcs_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result queue lets the next beat start while a result waits to be popped.
  mcs_fifo #(
    .WIDTH($bits(mcs_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .pop   (out_pop),
    .wdata (res_data),
    .rdata (res_raw),
    .full  (res_full),
    .empty (out_empty)
  );

  assign res_head               = mcs_pkg::res_t'(res_raw);
  assign out_channel            = res_head.channel;
  assign out_value              = res_head.value;
  assign out_peak_window_active = res_head.active;

endmodule

// ===== tb/curve_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the multichannel curve smoother: watches the input, result and
// configuration channels, predicts every result beat and compares it field by field.
// Depends on mcs_pkg for the port widths, register indexes and the result type.
module curve_result_checker #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_full,
  input  logic [mcs_pkg::CH_W-1:0]    in_channel,
  input  logic [mcs_pkg::VAL_W-1:0]   in_new_value,
  input  logic [mcs_pkg::DT_W-1:0]    in_frame_time,
  input  logic [mcs_pkg::ALPHA_W-1:0] in_blend_alpha,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  logic [mcs_pkg::CH_W-1:0]    out_channel,
  input  logic [mcs_pkg::VAL_W-1:0]   out_value,
  input  logic                        out_peak_window_active,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [4:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  input  logic                        cfg_pready,
  output int                          errors,
  output int                          outstanding
);

  localparam longint VAL_MAX = 64'sd8388607;
  localparam longint VAL_MIN = -64'sd8388608;

  // Shadow copy of the settings registers.
  logic                      peak_en;
  logic [mcs_pkg::VAL_W-1:0] peak_thr;
  logic [mcs_pkg::VAL_W-1:0] peak_hold;
  logic [mcs_pkg::VAL_W-1:0] peak_rate;
  logic [mcs_pkg::VAL_W-1:0] smooth_rate;
  logic                      const_mode;

  // Per-channel state of the smoother.
  logic signed [mcs_pkg::VAL_W-1:0] smooth_st [NUM_CHANNELS];
  logic signed [mcs_pkg::VAL_W-1:0] prev_st   [NUM_CHANNELS];
  logic signed [mcs_pkg::VAL_W-1:0] peak_st   [NUM_CHANNELS];
  logic        [mcs_pkg::VAL_W-1:0] timer_st  [NUM_CHANNELS];
  logic                             timer_on  [NUM_CHANNELS];

  mcs_pkg::res_t pending_results [$];

  function automatic logic signed [mcs_pkg::VAL_W-1:0] sat_val(input longint x);
    if (x > VAL_MAX) return VAL_MAX[mcs_pkg::VAL_W-1:0];
    if (x < VAL_MIN) return VAL_MIN[mcs_pkg::VAL_W-1:0];
    return x[mcs_pkg::VAL_W-1:0];
  endfunction

  // a * b / 2^16, rounded to nearest with ties away from zero.
  function automatic longint round_mul(input longint a, input longint unsigned b);
    longint unsigned mag;
    longint unsigned r;
    mag = (a < 0) ? -a : a;
    r = (mag * b + 64'd32768) >> 16;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [mcs_pkg::VAL_W-1:0] exp_toward(
    input logic signed [mcs_pkg::VAL_W-1:0] a,
    input logic signed [mcs_pkg::VAL_W-1:0] b,
    input logic [mcs_pkg::VAL_W-1:0] rate,
    input logic [mcs_pkg::DT_W-1:0] dt
  );
    longint unsigned r64;
    longint unsigned d64;
    longint unsigned factor;
    r64 = 64'(rate);
    d64 = 64'(dt);
    factor = (r64 * d64) >> 16;
    return sat_val(longint'(a) + round_mul(longint'(b) - longint'(a), factor));
  endfunction

  function automatic logic signed [mcs_pkg::VAL_W-1:0] const_toward(
    input logic signed [mcs_pkg::VAL_W-1:0] a,
    input logic signed [mcs_pkg::VAL_W-1:0] b,
    input logic [mcs_pkg::VAL_W-1:0] rate,
    input logic [mcs_pkg::DT_W-1:0] dt
  );
    longint diff;
    longint unsigned mag;
    longint unsigned r64;
    longint unsigned d64;
    longint unsigned span;
    longint stride;
    diff = longint'(b) - longint'(a);
    mag = (diff < 0) ? -diff : diff;
    r64 = 64'(rate);
    d64 = 64'(dt);
    span = r64 * d64;
    if ((mag << 16) <= span) return b;
    stride = longint'(span >> 16);
    return sat_val((diff < 0) ? longint'(a) - stride : longint'(a) + stride);
  endfunction

  // Advances the state of one channel by one sample and returns the result it produces.
  function automatic mcs_pkg::res_t smooth_sample(
    input logic [mcs_pkg::CH_W-1:0] ch,
    input logic [mcs_pkg::VAL_W-1:0] raw,
    input logic [mcs_pkg::DT_W-1:0] dt,
    input logic [mcs_pkg::ALPHA_W-1:0] alpha_in
  );
    mcs_pkg::res_t r;
    logic signed [mcs_pkg::VAL_W-1:0] nv;
    logic signed [mcs_pkg::VAL_W-1:0] cur;
    logic signed [mcs_pkg::VAL_W-1:0] stepped;
    logic signed [mcs_pkg::VAL_W-1:0] outv;
    logic [mcs_pkg::ALPHA_W-1:0] alpha;
    logic active;
    longint diff;
    longint unsigned mag;
    longint unsigned thr64;
    longint unsigned dt64;
    longint unsigned next_t;
    nv = raw;
    outv = nv;
    active = 1'b0;
    alpha = (alpha_in > mcs_pkg::ALPHA_ONE) ? mcs_pkg::ALPHA_ONE : alpha_in;
    dt64 = 64'(dt);
    if (int'(ch) < NUM_CHANNELS) begin
      cur = smooth_st[ch];
      if (peak_en) begin
        diff = longint'(nv) - longint'(prev_st[ch]);
        mag = (diff < 0) ? -diff : diff;
        thr64 = 64'(peak_thr);
        if ((mag << 16) > thr64 * dt64) begin
          timer_st[ch] = '0;
          timer_on[ch] = 1'b1;
        end
        prev_st[ch] = nv;
        if (timer_on[ch]) begin
          if (timer_st[ch] < peak_hold) begin
            next_t = longint'(timer_st[ch]) + dt64;
            timer_st[ch] = (next_t > 64'hFFFFFF) ? 24'hFFFFFF
                                                 : next_t[mcs_pkg::VAL_W-1:0];
            peak_st[ch] = exp_toward(peak_st[ch], nv, peak_rate, dt);
            outv = peak_st[ch];
            active = 1'b1;
          end else begin
            timer_on[ch] = 1'b0;
          end
        end else begin
          peak_st[ch] = nv;
        end
      end
      if (smooth_rate != '0) begin
        stepped = const_mode ? const_toward(cur, nv, smooth_rate, dt)
                             : exp_toward(cur, nv, smooth_rate, dt);
        smooth_st[ch] = sat_val(longint'(nv) + round_mul(longint'(stepped) - longint'(nv),
                                                         64'(alpha)));
        outv = smooth_st[ch];
      end
    end
    r.channel = ch;
    r.value = outv;
    r.active = active;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    mcs_pkg::res_t got;
    mcs_pkg::res_t want;
    if (!rst_n) begin
      peak_en = 1'b0;
      peak_thr = '0;
      peak_hold = '0;
      peak_rate = '0;
      smooth_rate = '0;
      const_mode = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        smooth_st[c] = '0;
        prev_st[c] = '0;
        peak_st[c] = '0;
        timer_st[c] = '0;
        timer_on[c] = 1'b0;
      end
      pending_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        got.channel = out_channel;
        got.value = out_value;
        got.active = out_peak_window_active;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: ch %0d value %h active %b",
                     got.channel, got.value, got.active);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected ch %0d value %h active %b, ",
                        "got ch %0d value %h active %b"},
                       want.channel, want.value, want.active,
                       got.channel, got.value, got.active);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          mcs_pkg::REG_PEAK_EN:   peak_en = cfg_pwdata[0];
          mcs_pkg::REG_PEAK_THR:  peak_thr = cfg_pwdata[mcs_pkg::VAL_W-1:0];
          mcs_pkg::REG_PEAK_HOLD: peak_hold = cfg_pwdata[mcs_pkg::VAL_W-1:0];
          mcs_pkg::REG_PEAK_RATE: peak_rate = cfg_pwdata[mcs_pkg::VAL_W-1:0];
          mcs_pkg::REG_SMOOTH:    smooth_rate = cfg_pwdata[mcs_pkg::VAL_W-1:0];
          mcs_pkg::REG_CONST:     const_mode = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        pending_results.push_back(smooth_sample(in_channel, in_new_value, in_frame_time,
                                                in_blend_alpha));
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/multichannel_curve_smoother_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the curve smoother testbench: clock, reset, stimulus on the input and
// configuration ports, result draining and the verdict.
// Depends on mcs_pkg, the block itself and curve_result_checker.
module multichannel_curve_smoother_unit_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 165;

  logic                        clk;
  logic                        rst_n;
  logic                        in_push;
  logic                        in_full;
  logic [mcs_pkg::CH_W-1:0]    in_channel;
  logic [mcs_pkg::VAL_W-1:0]   in_new_value;
  logic [mcs_pkg::DT_W-1:0]    in_frame_time;
  logic [mcs_pkg::ALPHA_W-1:0] in_blend_alpha;
  logic                        out_empty;
  logic                        out_pop;
  logic [mcs_pkg::CH_W-1:0]    out_channel;
  logic [mcs_pkg::VAL_W-1:0]   out_value;
  logic                        out_peak_window_active;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [4:0]                  cfg_paddr;
  logic [31:0]                 cfg_pwdata;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;

  int errors;
  int outstanding;
  int cycle_cnt = 0;
  bit quiet_phase = 1'b0;
  int long_hold_ask = 0;
  logic signed [mcs_pkg::VAL_W-1:0] last_val [16];

  multichannel_curve_smoother_unit #(.NUM_CHANNELS(16)) dut (.*);

  curve_result_checker #(.NUM_CHANNELS(16)) result_chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** multichannel_curve_smoother_unit: FAILED **");
      $finish;
    end
  end

  // Result side: random pop bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != long_hold_ask) begin
        holds_seen = long_hold_ask;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet_phase && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // All tasks are entered and left at a falling edge.
  task automatic send_item(input logic [mcs_pkg::CH_W-1:0] ch,
                           input logic [mcs_pkg::VAL_W-1:0] val,
                           input logic [mcs_pkg::DT_W-1:0] dt,
                           input logic [mcs_pkg::ALPHA_W-1:0] alpha);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_channel <= ch;
    in_new_value <= val;
    in_frame_time <= dt;
    in_blend_alpha <= alpha;
    last_val[ch] = val;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic en, input logic [23:0] thr, input logic [23:0] hold,
                            input logic [23:0] rate, input logic [23:0] smooth,
                            input logic cmode);
    write_reg(mcs_pkg::REG_PEAK_EN, {31'd0, en});
    write_reg(mcs_pkg::REG_PEAK_THR, {8'd0, thr});
    write_reg(mcs_pkg::REG_PEAK_HOLD, {8'd0, hold});
    write_reg(mcs_pkg::REG_PEAK_RATE, {8'd0, rate});
    write_reg(mcs_pkg::REG_SMOOTH, {8'd0, smooth});
    write_reg(mcs_pkg::REG_CONST, {31'd0, cmode});
  endtask

  function automatic logic [23:0] pick24(input int unsigned mid_max);
    case ($urandom_range(0, 3))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, mid_max));
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // Half small moves, mostly on a few channels, so that peak windows open, run and expire,
  // mixed with large jumps, extremes and fully random samples.
  task automatic send_random_item();
    int ch;
    int v;
    int roll;
    logic [mcs_pkg::DT_W-1:0] dt;
    logic [mcs_pkg::ALPHA_W-1:0] alpha;
    ch = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    roll = $urandom_range(0, 9);
    if (roll < 5)
      v = int'(last_val[ch]) + int'($urandom_range(0, 512)) - 256;
    else if (roll < 7)
      v = int'(last_val[ch]) + (($urandom_range(0, 1) == 1) ? 1 : -1) *
          int'($urandom_range(24'h100000, 24'h7FFFFF));
    else if (roll == 7)
      v = ($urandom_range(0, 1) == 1) ? 8388607 : -8388608;
    else
      v = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    roll = $urandom_range(0, 9);
    if (roll == 0) dt = '0;
    else if (roll == 1) dt = 16'hFFFF;
    else if (roll < 6) dt = 16'($urandom_range(1, 4096));
    else dt = 16'($urandom_range(0, 65535));
    roll = $urandom_range(0, 19);
    if (roll < 3) alpha = '0;
    else if (roll < 6) alpha = mcs_pkg::ALPHA_ONE;
    else if (roll < 8) alpha = 17'($urandom_range(65537, 131071));
    else alpha = 17'($urandom_range(0, 65536));
    send_item(ch[mcs_pkg::CH_W-1:0], v[mcs_pkg::VAL_W-1:0], dt, alpha);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_channel = '0;
    in_new_value = '0;
    in_frame_time = '0;
    in_blend_alpha = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int c = 0; c < 16; c++) last_val[c] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Settings at reset: nothing smooths, so each sample passes through raw.
    send_item(4'd0, 24'h7FFFFF, 16'hFFFF, 17'h1FFFF);
    send_item(4'd15, 24'h800000, 16'h0000, 17'h00000);
    send_item(4'd5, 24'h000000, 16'h8000, mcs_pkg::ALPHA_ONE);
    send_item(4'd1, 24'h000001, 16'h0001, 17'h10001);
    drain();

    // A jump opens the peak window, which then runs four steps and expires.
    set_config(1'b1, 24'h010000, 24'h002000, 24'h040000, 24'h000000, 1'b0);
    send_item(4'd2, 24'h100000, 16'h0800, 17'h00000);
    repeat (5) send_item(4'd2, 24'h100000, 16'h0800, 17'h00000);
    // Zero frame time: a nonzero jump reopens the window, a repeated sample does not.
    send_item(4'd2, 24'h100010, 16'h0000, 17'h00000);
    send_item(4'd2, 24'h100010, 16'h0000, 17'h00000);
    send_item(4'd4, 24'h000000, 16'h0800, 17'h00000);
    drain();

    // A hold time of zero never lets the window run; constant steps and their snap.
    set_config(1'b1, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h020000, 1'b1);
    send_item(4'd7, 24'h300000, 16'h1000, 17'h08000);
    send_item(4'd7, 24'h300000, 16'hFFFF, mcs_pkg::ALPHA_ONE);
    send_item(4'd7, 24'h800000, 16'h4000, mcs_pkg::ALPHA_ONE);
    send_item(4'd7, 24'h7FFFFF, 16'hFFFF, 17'h1FFFF);
    drain();

    // One window held long enough for the peak timer to saturate and then expire.
    set_config(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h000100, 24'h000000, 1'b0);
    send_item(4'd9, 24'h123456, 16'h0000, mcs_pkg::ALPHA_ONE);
    send_item(4'd9, 24'h123457, 16'h0000, mcs_pkg::ALPHA_ONE);
    repeat (262) send_item(4'd9, 24'h123457, 16'hFFFF, 17'($urandom_range(0, 65536)));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        set_config(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
      else
        set_config($urandom_range(0, 3) != 0, pick24(24'h040000), pick24(24'h010000),
                   pick24(24'h100000), pick24(24'h100000), 1'($urandom_range(0, 1)));
      // The receiver holds off while the sender keeps going, so the input backs up.
      if (p == 2) long_hold_ask++;
      if (p == PHASES - 1) quiet_phase = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end

    repeat (40) @(negedge clk);
    if (errors == 0)
      $display("** multichannel_curve_smoother_unit: PASSED **");
    else
      $display("** multichannel_curve_smoother_unit: FAILED **");
    $finish;
  end

endmodule

// ===== multichannel_curve_smoother_unit.f =====
design/mcs_pkg.sv
design/mcs_fifo.sv
design/mcs_front.sv
design/mcs_back.sv
design/multichannel_curve_smoother_unit.sv
tb/curve_result_checker.sv
tb/multichannel_curve_smoother_unit_test.sv
